### src/ffsa_pkg.sv
// shared types and constants of the first-fit segment allocator
`default_nettype none

package ffsa_pkg;

    localparam int ADDR_W           = 24;
    localparam int CAP_W            = 25;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int ALIGN_MASK       = 7;
    localparam int MIN_TAIL_BYTES   = 8;
    localparam logic [CAP_W-1:0] CAP_MAX = 25'h100_0000;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_INIT  = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] bytes;
        logic              is_free;
    } seg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INIT,
        S_SCAN,
        S_PREP,
        S_SHIFT_INIT,
        S_SHIFT,
        S_SPLIT_TAIL,
        S_SPLIT_HEAD,
        S_TAKE,
        S_COMPACT,
        S_COMPACT_END,
        S_SUM,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_SCAN,
        OP_PREP,
        OP_SHIFT_INIT,
        OP_SHIFT,
        OP_SPLIT_TAIL,
        OP_SPLIT_HEAD,
        OP_TAKE,
        OP_COMPACT,
        OP_COMPACT_END,
        OP_SUM,
        OP_EMIT,
        OP_WAIT
    } op_t;

    typedef struct packed {
        req_type_t req_type;
        logic      early_refuse;
        logic      scan_done;
        logic      hit;
        logic      split_ok;
        logic      shift_done;
        logic      pass_done;
        logic      out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### src/ffsa_if.sv
// request, response and configuration channels
`default_nettype none

interface ffsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [23:0] req_size;
    logic [23:0] data_addr;
    modport source (output valid, output req_type, output req_size, output data_addr,
                    input ready);
    modport sink (input valid, input req_type, input req_size, input data_addr,
                  output ready);
endinterface

interface ffsa_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [23:0] grant_addr;
    logic [23:0] used_bytes;
    logic [23:0] free_bytes;
    modport source (output valid, output status, output grant_addr, output used_bytes,
                    output free_bytes, input ready);
    modport sink (input valid, input status, input grant_addr, input used_bytes,
                  input free_bytes, output ready);
endinterface

interface ffsa_cfg_if;
    logic        valid;
    logic        ready;
    logic [24:0] pool_capacity;
    modport source (output valid, output pool_capacity, input ready);
    modport sink (input valid, input pool_capacity, output ready);
endinterface

`default_nettype wire

### src/ffsa_datapath.sv
// segment table memory, pass counters and result registers
`default_nettype none

module ffsa_datapath #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffsa_pkg::op_t         op,
    output ffsa_pkg::dp_status_t  st,
    input  logic [1:0]            req_type,
    input  logic [23:0]           req_size,
    input  logic [23:0]           data_addr,
    input  logic                  cfg_we,
    input  logic [24:0]           cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  status,
    output logic [23:0]           grant_addr,
    output logic [23:0]           used_bytes,
    output logic [23:0]           free_bytes
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = ffsa_pkg::ADDR_W;
    localparam int KW = ffsa_pkg::CAP_W;
    localparam logic [AW-1:0] HB = AW'(HEADER_BYTES);

    ffsa_pkg::seg_t mem [MAX_SEGMENTS];
    ffsa_pkg::seg_t mem_q_reg;

    logic           we;
    logic [IW-1:0]  waddr;
    ffsa_pkg::seg_t wdata;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           ready_reg, ready_next;
    logic [KW-1:0]  cap_reg, cap_next;
    logic [CW-1:0]  rd_idx_reg, rd_idx_next;
    logic           dv_reg, dv_next;
    logic [CW-1:0]  didx_reg, didx_next;
    logic           hit_reg, hit_next;
    logic [IW-1:0]  hit_idx_reg, hit_idx_next;
    ffsa_pkg::seg_t hit_ent_reg, hit_ent_next;
    logic           pv_reg, pv_next;
    ffsa_pkg::seg_t pend_reg, pend_next;
    logic [CW-1:0]  wr_reg, wr_next;
    logic [AW-1:0]  acc_reg, acc_next;
    ffsa_pkg::req_type_t type_reg, type_next;
    logic [KW-1:0]  size_reg, size_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic           status_reg, status_next;
    logic [AW-1:0]  grant_reg, grant_next;
    logic [AW-1:0]  used_reg, used_next;
    logic           out_valid_reg, out_valid_next;
    logic           o_status_reg, o_status_next;
    logic [AW-1:0]  o_grant_reg, o_grant_next;
    logic [AW-1:0]  o_used_reg, o_used_next;
    logic [AW-1:0]  o_free_reg, o_free_next;

    ffsa_pkg::seg_t cur;
    logic           fwd_issue, pass_done, fit, own, match_hit, split_ok, shift_more;
    logic [KW-1:0]  cap_lim;
    logic           cap_ok;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[rd_idx_reg[IW-1:0]];
    end

    always_comb
    begin
        cur = mem_q_reg;
        // the segment being freed counts as free during the merge pass
        if (op == ffsa_pkg::OP_COMPACT && didx_reg == CW'(hit_idx_reg))
        begin
            cur.is_free = 1'b1;
        end
    end

    assign fwd_issue  = rd_idx_reg < cnt_reg;
    assign pass_done  = (rd_idx_reg == cnt_reg) && !dv_reg;
    assign fit        = cur.is_free && ({1'b0, cur.bytes} >= size_reg);
    assign own        = !cur.is_free && ((cur.start + HB) == addr_reg);
    assign match_hit  = (type_reg == ffsa_pkg::REQ_ALLOC) ? fit : own;
    assign split_ok   = ({2'b00, hit_ent_reg.bytes} >=
                         {1'b0, size_reg} + 26'(HEADER_BYTES) + 26'(ffsa_pkg::MIN_TAIL_BYTES))
                        && (cnt_reg < CW'(MAX_SEGMENTS));
    assign shift_more = rd_idx_reg > CW'(hit_idx_reg);
    assign cap_lim    = (cap_reg > ffsa_pkg::CAP_MAX) ? ffsa_pkg::CAP_MAX : cap_reg;
    assign cap_ok     = cap_lim > KW'(HEADER_BYTES);

    always_comb
    begin
        st.req_type     = type_reg;
        st.early_refuse = !ready_reg ||
                          (type_reg == ffsa_pkg::REQ_ALLOC && size_reg == '0);
        st.scan_done    = hit_reg || pass_done;
        st.hit          = hit_reg;
        st.split_ok     = split_ok;
        st.shift_done   = !shift_more && !dv_reg;
        st.pass_done    = pass_done;
        st.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        ready_next     = ready_reg;
        cap_next       = cfg_we ? cfg_data : cap_reg;
        rd_idx_next    = rd_idx_reg;
        dv_next        = dv_reg;
        didx_next      = didx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_ent_next   = hit_ent_reg;
        pv_next        = pv_reg;
        pend_next      = pend_reg;
        wr_next        = wr_reg;
        acc_next       = acc_reg;
        type_next      = type_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_status_next  = o_status_reg;
        o_grant_next   = o_grant_reg;
        o_used_next    = o_used_reg;
        o_free_next    = o_free_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = pend_reg;

        // forward passes start from entry zero with empty accumulators
        if (op == ffsa_pkg::OP_NONE || op == ffsa_pkg::OP_PREP ||
            op == ffsa_pkg::OP_INIT || op == ffsa_pkg::OP_TAKE ||
            op == ffsa_pkg::OP_SPLIT_HEAD || op == ffsa_pkg::OP_COMPACT_END)
        begin
            rd_idx_next = '0;
            dv_next     = 1'b0;
            hit_next    = 1'b0;
            pv_next     = 1'b0;
            wr_next     = '0;
            acc_next    = '0;
        end

        if (op == ffsa_pkg::OP_SCAN || op == ffsa_pkg::OP_COMPACT || op == ffsa_pkg::OP_SUM)
        begin
            if (fwd_issue && !(op == ffsa_pkg::OP_SCAN && hit_reg))
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
                dv_next     = 1'b1;
                didx_next   = rd_idx_reg;
            end
            else
            begin
                dv_next = 1'b0;
            end
        end

        unique case (op)
            ffsa_pkg::OP_LOAD:
            begin
                type_next   = ffsa_pkg::req_type_t'(req_type);
                size_next   = ({1'b0, req_size} + KW'(ffsa_pkg::ALIGN_MASK)) &
                              ~KW'(ffsa_pkg::ALIGN_MASK);
                addr_next   = data_addr;
                status_next = 1'b1;
                grant_next  = '0;
                used_next   = '0;
            end
            ffsa_pkg::OP_INIT:
            begin
                if (cap_ok)
                begin
                    we          = 1'b1;
                    waddr       = '0;
                    wdata       = '{start: '0, bytes: AW'(cap_lim - KW'(HEADER_BYTES)),
                                    is_free: 1'b1};
                    cnt_next    = CW'(1);
                    ready_next  = 1'b1;
                    status_next = 1'b0;
                end
                else
                begin
                    cnt_next   = '0;
                    ready_next = 1'b0;
                end
            end
            ffsa_pkg::OP_SCAN:
            begin
                if (dv_reg && !hit_reg && match_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = didx_reg[IW-1:0];
                    hit_ent_next = cur;
                end
            end
            ffsa_pkg::OP_PREP:
            begin
                if (hit_reg && type_reg == ffsa_pkg::REQ_QUERY)
                begin
                    used_next   = hit_ent_reg.bytes;
                    status_next = 1'b0;
                end
                if (hit_reg && type_reg == ffsa_pkg::REQ_FREE)
                begin
                    status_next = 1'b0;
                end
            end
            ffsa_pkg::OP_SHIFT_INIT:
            begin
                rd_idx_next = cnt_reg - 1'b1;
                dv_next     = 1'b0;
            end
            ffsa_pkg::OP_SHIFT:
            begin
                // walk down from the last entry to the one after the hit, moving each one up a place
                if (shift_more)
                begin
                    rd_idx_next = rd_idx_reg - 1'b1;
                    dv_next     = 1'b1;
                    didx_next   = rd_idx_reg;
                end
                else
                begin
                    dv_next = 1'b0;
                end
                if (dv_reg)
                begin
                    we    = 1'b1;
                    waddr = didx_reg[IW-1:0] + 1'b1;
                    wdata = mem_q_reg;
                end
            end
            ffsa_pkg::OP_SPLIT_TAIL:
            begin
                we    = 1'b1;
                waddr = hit_idx_reg + 1'b1;
                wdata = '{start: hit_ent_reg.start + HB + size_reg[AW-1:0],
                          bytes: hit_ent_reg.bytes - size_reg[AW-1:0] - HB,
                          is_free: 1'b1};
            end
            ffsa_pkg::OP_SPLIT_HEAD:
            begin
                we          = 1'b1;
                waddr       = hit_idx_reg;
                wdata       = '{start: hit_ent_reg.start, bytes: size_reg[AW-1:0],
                                is_free: 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                grant_next  = hit_ent_reg.start + HB;
                status_next = 1'b0;
            end
            ffsa_pkg::OP_TAKE:
            begin
                we          = 1'b1;
                waddr       = hit_idx_reg;
                wdata       = '{start: hit_ent_reg.start, bytes: hit_ent_reg.bytes,
                                is_free: 1'b0};
                grant_next  = hit_ent_reg.start + HB;
                status_next = 1'b0;
            end
            ffsa_pkg::OP_COMPACT:
            begin
                if (dv_reg)
                begin
                    if (!pv_reg)
                    begin
                        pend_next = cur;
                        pv_next   = 1'b1;
                    end
                    else if (pend_reg.is_free && cur.is_free)
                    begin
                        pend_next.bytes = pend_reg.bytes + HB + cur.bytes;
                    end
                    else
                    begin
                        we        = 1'b1;
                        waddr     = wr_reg[IW-1:0];
                        wdata     = pend_reg;
                        wr_next   = wr_reg + 1'b1;
                        pend_next = cur;
                    end
                end
            end
            ffsa_pkg::OP_COMPACT_END:
            begin
                we       = 1'b1;
                waddr    = wr_reg[IW-1:0];
                wdata    = pend_reg;
                cnt_next = wr_reg + 1'b1;
            end
            ffsa_pkg::OP_SUM:
            begin
                if (dv_reg && cur.is_free)
                begin
                    acc_next = acc_reg + cur.bytes;
                end
            end
            ffsa_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
                o_status_next  = status_reg;
                o_grant_next   = grant_reg;
                o_used_next    = used_reg;
                o_free_next    = acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ready_reg     <= 1'b0;
            cap_reg       <= '0;
            rd_idx_reg    <= '0;
            dv_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ready_reg     <= ready_next;
            cap_reg       <= cap_next;
            rd_idx_reg    <= rd_idx_next;
            dv_reg        <= dv_next;
            hit_reg       <= hit_next;
            pv_reg        <= pv_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg     <= didx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_ent_reg  <= hit_ent_next;
        pend_reg     <= pend_next;
        acc_reg      <= acc_next;
        type_reg     <= type_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
        used_reg     <= used_next;
        o_status_reg <= o_status_next;
        o_grant_reg  <= o_grant_next;
        o_used_reg   <= o_used_next;
        o_free_reg   <= o_free_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = o_status_reg;
    assign grant_addr = o_grant_reg;
    assign used_bytes = o_used_reg;
    assign free_bytes = o_free_reg;

endmodule

`default_nettype wire

### src/ffsa_ctrl.sv
// request sequencer of the segment allocator
`default_nettype none

module ffsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffsa_pkg::dp_status_t st,
    output ffsa_pkg::op_t        op
);

    ffsa_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ffsa_pkg::S_DECODE;
                end
            end
            ffsa_pkg::S_DECODE:
            begin
                priority if (st.req_type == ffsa_pkg::REQ_INIT)
                begin
                    state_next = ffsa_pkg::S_INIT;
                end
                else if (st.early_refuse)
                begin
                    state_next = ffsa_pkg::S_SUM;
                end
                else
                begin
                    state_next = ffsa_pkg::S_SCAN;
                end
            end
            ffsa_pkg::S_INIT:
            begin
                state_next = ffsa_pkg::S_SUM;
            end
            ffsa_pkg::S_SCAN:
            begin
                if (st.scan_done)
                begin
                    priority if (st.hit && st.req_type == ffsa_pkg::REQ_ALLOC)
                    begin
                        state_next = st.split_ok ? ffsa_pkg::S_SHIFT_INIT : ffsa_pkg::S_TAKE;
                    end
                    else
                    begin
                        state_next = ffsa_pkg::S_PREP;
                    end
                end
            end
            ffsa_pkg::S_PREP:
            begin
                state_next = (st.hit && st.req_type == ffsa_pkg::REQ_FREE) ?
                             ffsa_pkg::S_COMPACT : ffsa_pkg::S_SUM;
            end
            ffsa_pkg::S_SHIFT_INIT:
            begin
                state_next = ffsa_pkg::S_SHIFT;
            end
            ffsa_pkg::S_SHIFT:
            begin
                if (st.shift_done)
                begin
                    state_next = ffsa_pkg::S_SPLIT_TAIL;
                end
            end
            ffsa_pkg::S_SPLIT_TAIL:
            begin
                state_next = ffsa_pkg::S_SPLIT_HEAD;
            end
            ffsa_pkg::S_SPLIT_HEAD,
            ffsa_pkg::S_TAKE,
            ffsa_pkg::S_COMPACT_END:
            begin
                state_next = ffsa_pkg::S_SUM;
            end
            ffsa_pkg::S_COMPACT:
            begin
                if (st.pass_done)
                begin
                    state_next = ffsa_pkg::S_COMPACT_END;
                end
            end
            ffsa_pkg::S_SUM:
            begin
                if (st.pass_done)
                begin
                    state_next = ffsa_pkg::S_DONE;
                end
            end
            ffsa_pkg::S_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = ffsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffsa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ffsa_pkg::S_IDLE);
        unique case (state_reg)
            ffsa_pkg::S_IDLE:        op = in_valid ? ffsa_pkg::OP_LOAD : ffsa_pkg::OP_NONE;
            ffsa_pkg::S_DECODE:      op = ffsa_pkg::OP_NONE;
            ffsa_pkg::S_INIT:        op = ffsa_pkg::OP_INIT;
            ffsa_pkg::S_SCAN:        op = ffsa_pkg::OP_SCAN;
            ffsa_pkg::S_PREP:        op = ffsa_pkg::OP_PREP;
            ffsa_pkg::S_SHIFT_INIT:  op = ffsa_pkg::OP_SHIFT_INIT;
            ffsa_pkg::S_SHIFT:       op = ffsa_pkg::OP_SHIFT;
            ffsa_pkg::S_SPLIT_TAIL:  op = ffsa_pkg::OP_SPLIT_TAIL;
            ffsa_pkg::S_SPLIT_HEAD:  op = ffsa_pkg::OP_SPLIT_HEAD;
            ffsa_pkg::S_TAKE:        op = ffsa_pkg::OP_TAKE;
            ffsa_pkg::S_COMPACT:     op = ffsa_pkg::OP_COMPACT;
            ffsa_pkg::S_COMPACT_END: op = ffsa_pkg::OP_COMPACT_END;
            ffsa_pkg::S_SUM:         op = ffsa_pkg::OP_SUM;
            ffsa_pkg::S_DONE:        op = st.out_free ? ffsa_pkg::OP_EMIT : ffsa_pkg::OP_WAIT;
            default:                 op = ffsa_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffsa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/first_fit_segment_allocator.sv
// First-fit segment allocator: keeps an address-ordered table of up to MAX_SEGMENTS
// segments (header of HEADER_BYTES plus data area) in a single-port-write memory and
// serves one request at a time. Each request walks the table one entry per cycle:
// a lookup pass (none for an init or a refused request), then for a split alloc a
// shift pass that opens a slot, for a free a merge pass that rewrites the table with
// neighbors joined, and always a final pass that sums the free bytes. The table walk
// goes through the one memory read port. A result waits in an output register while
// the next request is taken. Configuration writes are taken in any cycle.
`default_nettype none

module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ffsa_req_if.sink    req,
    ffsa_rsp_if.source  rsp,
    ffsa_cfg_if.sink    cfg
);

    ffsa_pkg::op_t        op;
    ffsa_pkg::dp_status_t st;

    assign cfg.ready = 1'b1;

    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .op       (op)
    );

    ffsa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .st         (st),
        .req_type   (req.req_type),
        .req_size   (req.req_size),
        .data_addr  (req.data_addr),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.pool_capacity),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .status     (rsp.status),
        .grant_addr (rsp.grant_addr),
        .used_bytes (rsp.used_bytes),
        .free_bytes (rsp.free_bytes)
    );

    // a result is only loaded into a free output slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        op == ffsa_pkg::OP_EMIT |-> (!rsp.valid || rsp.ready))
        else $error("result overwrote a waiting beat");

    // a split only starts when the tail and a table slot are there
    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        op == ffsa_pkg::OP_SHIFT_INIT |-> st.split_ok && st.hit)
        else $error("split without room");

    // an accepted beat is followed by decode, never by a second load
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready && op == ffsa_pkg::OP_NONE)
        else $error("request taken while busy");

endmodule

`default_nettype wire
